// ===== design/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the click boundary copy splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  localparam int ADDR_BITS   = 24;
  localparam int LEN_W       = 15;
  localparam int CLICK_W     = 10;
  localparam int CLICK_BYTES = 1 << CLICK_W;
  localparam int CLEN_W      = CLICK_W + 1;
  localparam int MAX_LEN     = 16384;
  localparam int MAX_RESULTS = 33;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ASC   = 2'd1,
    MODE_DESC  = 2'd2,
    MODE_LIN   = 2'd3
  } mode_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

  typedef struct packed {
    mode_t                mode;
    logic [ADDR_BITS-1:0] src;
    logic [ADDR_BITS-1:0] dst;
    logic [LEN_W-1:0]     len;
  } req_t;

endpackage

`default_nettype wire

// ===== design/click_boundary_copy_splitter.sv =====
// ----------------------------------------------------------------------------
// click_boundary_copy_splitter
// Splits a transfer request into chunks that never cross a destination click boundary.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake         Payload
//  in_      input      in_valid/stall    mode, src_addr, dst_addr, length
//  out_     output     out_valid/stall   chunk_src, chunk_dst, chunk_len, is_last
//
//  A request is loaded from the queue in BK_IDLE; in BK_RUN the back end then
//  emits one chunk word per cycle while the output register is empty or
//  out_stall is low, and pops the next request only after its last chunk.
//  A two-word queue lets the front accept requests while the back end works.
//  Reset is synchronous and clears the queue and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module click_boundary_copy_splitter
  import ccs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_mode,
  input  wire logic [ADDR_BITS-1:0] in_src_addr,
  input  wire logic [ADDR_BITS-1:0] in_dst_addr,
  input  wire logic [LEN_W-1:0]     in_length,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ADDR_BITS-1:0]      out_chunk_src,
  output logic [ADDR_BITS-1:0]      out_chunk_dst,
  output logic [CLEN_W-1:0]         out_chunk_len,
  output logic                      out_is_last
);

  logic q_push, q_pop, q_full, q_empty;
  req_t push_req, pop_req;

  ccs_front u_front (
    .in_valid    (in_valid),
    .in_mode     (in_mode),
    .in_src_addr (in_src_addr),
    .in_dst_addr (in_dst_addr),
    .in_length   (in_length),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_req       (push_req)
  );

  ccs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .pop      (q_pop),
    .pop_req  (pop_req),
    .full     (q_full),
    .empty    (q_empty)
  );

  ccs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_req         (pop_req),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_chunk_src (out_chunk_src),
    .out_chunk_dst (out_chunk_dst),
    .out_chunk_len (out_chunk_len),
    .out_is_last   (out_is_last)
  );

endmodule

`default_nettype wire

// ===== design/ccs_front.sv =====
// ----------------------------------------------------------------------------
// ccs_front
// Accepts request words, saturates the length, drops empty requests, zeroes the
// source of clear requests and turns descending copies into end addresses before queueing them.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_front
  import ccs_pkg::*;
(
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_mode,
  input  wire logic [ADDR_BITS-1:0] in_src_addr,
  input  wire logic [ADDR_BITS-1:0] in_dst_addr,
  input  wire logic [LEN_W-1:0]     in_length,
  output logic                      in_stall,
  input  wire logic                 q_full,
  output logic                      q_push,
  output req_t                      q_req
);

  mode_t                mode;
  logic [LEN_W-1:0]     len_sat;
  logic [ADDR_BITS-1:0] src0;

  always_comb begin
    mode    = mode_t'(in_mode);
    len_sat = (in_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_length;
    src0    = (mode == MODE_CLEAR) ? '0 : in_src_addr;
    q_req.mode = mode;
    q_req.len  = len_sat;
    if (mode == MODE_DESC) begin
      q_req.src = src0 + ADDR_BITS'(len_sat);
      q_req.dst = in_dst_addr + ADDR_BITS'(len_sat);
    end else begin
      q_req.src = src0;
      q_req.dst = in_dst_addr;
    end
    in_stall = q_full;
    q_push   = in_valid && !q_full && (in_length != '0);
  end

endmodule

`default_nettype wire

// ===== design/ccs_fifo.sv =====
// ----------------------------------------------------------------------------
// ccs_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_fifo
  import ccs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  req_t      push_req,
  input  wire logic pop,
  output req_t      pop_req,
  output logic      full,
  output logic      empty
);

  req_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
    empty   = (cnt_r == '0);
    pop_req = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

`default_nettype wire

// ===== design/ccs_back.sv =====
// ----------------------------------------------------------------------------
// ccs_back
// Walks one queued request and emits one chunk word per cycle into the output
// register while it is empty or out_stall is low, cutting at click boundaries.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_back
  import ccs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  req_t                      q_req,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ADDR_BITS-1:0]      out_chunk_src,
  output logic [ADDR_BITS-1:0]      out_chunk_dst,
  output logic [CLEN_W-1:0]         out_chunk_len,
  output logic                      out_is_last
);

  bk_state_t            state_r, state_nxt;
  mode_t                mode_r, mode_nxt;
  logic [ADDR_BITS-1:0] s_r, s_nxt;
  logic [ADDR_BITS-1:0] d_r, d_nxt;
  logic [LEN_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic                 ov_r, ov_nxt;
  logic [ADDR_BITS-1:0] osrc_r, osrc_nxt;
  logic [ADDR_BITS-1:0] odst_r, odst_nxt;
  logic [CLEN_W-1:0]    olen_r, olen_nxt;
  logic                 olast_r, olast_nxt;

  logic                 emit;
  logic [CLEN_W-1:0]    room_s, room_d, c;
  logic [CLICK_W-1:0]   s_low, d_low;
  logic [LEN_W-1:0]     n_rem;
  logic                 last;

  always_comb begin
    s_low = s_r[CLICK_W-1:0] - 1'b1;
    d_low = d_r[CLICK_W-1:0] - 1'b1;
    if (mode_r == MODE_DESC) begin
      room_s = {1'b0, s_low} + 1'b1;
      room_d = {1'b0, d_low} + 1'b1;
    end else begin
      room_s = CLEN_W'(CLICK_BYTES) - {1'b0, s_r[CLICK_W-1:0]};
      room_d = CLEN_W'(CLICK_BYTES) - {1'b0, d_r[CLICK_W-1:0]};
    end
    c = room_d;
    if ((mode_r == MODE_ASC || mode_r == MODE_DESC) && room_s < room_d) begin
      c = room_s;
    end
    if (LEN_W'(c) > n_r) begin
      c = n_r[CLEN_W-1:0];
    end
    n_rem = n_r - LEN_W'(c);
    last  = (n_rem == '0) || (k_r == CNT_W'(MAX_RESULTS - 1));
    emit  = (state_r == BK_RUN) && (!ov_r || !out_stall);

    state_nxt = state_r;
    mode_nxt  = mode_r;
    s_nxt     = s_r;
    d_nxt     = d_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    q_pop     = 1'b0;
    ov_nxt    = ov_r && out_stall;
    osrc_nxt  = osrc_r;
    odst_nxt  = odst_r;
    olen_nxt  = olen_r;
    olast_nxt = olast_r;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          mode_nxt  = q_req.mode;
          s_nxt     = q_req.src;
          d_nxt     = q_req.dst;
          n_nxt     = q_req.len;
          k_nxt     = '0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit) begin
          ov_nxt    = 1'b1;
          olen_nxt  = c;
          olast_nxt = last;
          n_nxt     = n_rem;
          k_nxt     = k_r + 1'b1;
          if (mode_r == MODE_DESC) begin
            s_nxt    = s_r - ADDR_BITS'(c);
            d_nxt    = d_r - ADDR_BITS'(c);
            osrc_nxt = s_nxt;
            odst_nxt = d_nxt;
          end else begin
            osrc_nxt = s_r;
            odst_nxt = d_r;
            if (mode_r != MODE_CLEAR) begin
              s_nxt = s_r + ADDR_BITS'(c);
            end
            d_nxt = d_r + ADDR_BITS'(c);
          end
          if (last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    s_r     <= s_nxt;
    d_r     <= d_nxt;
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    osrc_r  <= osrc_nxt;
    odst_r  <= odst_nxt;
    olen_r  <= olen_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ov_r;
  assign out_chunk_src = osrc_r;
  assign out_chunk_dst = odst_r;
  assign out_chunk_len = olen_r;
  assign out_is_last   = olast_r;

endmodule

`default_nettype wire

// ===== design/ccs_checker.sv =====
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks for the click boundary copy splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_checker
  import ccs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [ADDR_BITS-1:0] out_chunk_src,
  input wire logic [ADDR_BITS-1:0] out_chunk_dst,
  input wire logic [CLEN_W-1:0]    out_chunk_len,
  input wire logic                 out_is_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chunk_src)
      && $stable(out_chunk_dst) && $stable(out_chunk_len) && $stable(out_is_last))
    else $error("A stalled chunk word changed or was withdrawn.");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chunk_len != '0 && out_chunk_len <= CLEN_W'(CLICK_BYTES))
    else $error("Chunk length is outside one click.");

  a_no_cross: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({2'b00, out_chunk_dst[CLICK_W-1:0]} + {1'b0, out_chunk_len})
      <= (CLEN_W + 1)'(CLICK_BYTES))
    else $error("Chunk crosses a destination click boundary.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Output or stall not cleared by reset.");

endmodule

bind click_boundary_copy_splitter ccs_checker u_ccs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_chunk_src (out_chunk_src),
  .out_chunk_dst (out_chunk_dst),
  .out_chunk_len (out_chunk_len),
  .out_is_last   (out_is_last)
);

`default_nettype wire
